// ===== hw/rtl/cbfc_pkg.sv =====
package cbfc_pkg;

  localparam int unsigned StressW = 32;
  localparam int unsigned StrengthW = 31;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned SumW = 33;
  localparam int unsigned PrinW = 35;
  localparam int unsigned RootW = 32;
  localparam int unsigned RadW = 64;
  localparam int unsigned OpW = 40;
  localparam int unsigned OpCntW = 6;
  localparam int unsigned AccW = 2 * OpW + 2;
  localparam int unsigned RootCntW = 5;

  localparam logic [CfgIdxW-1:0] RegTensile = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCompressive = 8'd1;
  localparam logic [StrengthW-1:0] CompressiveReset = 31'd65536;

  typedef struct packed {
    logic            start;
    logic            clear;
    logic            neg;
    logic            shr2;
    logic [OpW-1:0]  a;
    logic [OpW-1:0]  b;
  } mul_cmd_t;

endpackage

// ===== hw/rtl/cbfc_if.sv =====
interface cbfc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbfc_pkg::StressW-1:0]  stress_x;
  logic signed [cbfc_pkg::StressW-1:0]  stress_y;
  logic signed [cbfc_pkg::StressW-1:0]  shear_xy;
  logic                                 last_point;

  modport source (output valid, stress_x, stress_y, shear_xy, last_point, input ready);
  modport sink (input valid, stress_x, stress_y, shear_xy, last_point, output ready);
endinterface

interface cbfc_out_if;
  logic valid;
  logic ready;
  logic point_failed;
  logic element_failed;
  logic element_done;

  modport source (output valid, point_failed, element_failed, element_done, input ready);
  modport sink (input valid, point_failed, element_failed, element_done, output ready);
endinterface

interface cbfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbfc_pkg::CfgIdxW-1:0]     index;
  logic [cbfc_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cbfc_mul.sv =====
module cbfc_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cbfc_pkg::mul_cmd_t                   cmd_i,
  output logic                                 busy_o,
  output logic signed [cbfc_pkg::AccW-1:0]     acc_o
);

  logic [2*cbfc_pkg::OpW-1:0]      a_q, a_d;
  logic [cbfc_pkg::OpW-1:0]        b_q, b_d;
  logic signed [cbfc_pkg::AccW-1:0] acc_q, acc_d;
  logic [cbfc_pkg::OpCntW-1:0]     cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            neg_q, neg_d;
  logic signed [cbfc_pkg::AccW-1:0] addend;

  assign addend = $signed({2'b00, a_q});

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    if (busy_q) begin
      if (b_q[0]) begin
        acc_d = neg_q ? acc_q - addend : acc_q + addend;
      end
      a_d = {a_q[2*cbfc_pkg::OpW-2:0], 1'b0};
      b_d = {1'b0, b_q[cbfc_pkg::OpW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cbfc_pkg::OpCntW'(cbfc_pkg::OpW - 1)) begin
        busy_d = 1'b0;
      end
    end else if (cmd_i.start) begin
      a_d = {{cbfc_pkg::OpW{1'b0}}, cmd_i.a};
      b_d = cmd_i.b;
      neg_d = cmd_i.neg;
      cnt_d = '0;
      busy_d = 1'b1;
      if (cmd_i.clear) begin
        acc_d = '0;
      end
    end else if (cmd_i.shr2) begin
      acc_d = acc_q >>> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/cbfc_sqrt.sv =====
module cbfc_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cbfc_pkg::RadW-1:0]      rad_i,
  output logic                           busy_o,
  output logic [cbfc_pkg::RootW-1:0]     root_o
);

  localparam int unsigned RemW = cbfc_pkg::RootW + 3;

  logic [cbfc_pkg::RadW-1:0]       x_q, x_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [cbfc_pkg::RootW-1:0]      root_q, root_d;
  logic [cbfc_pkg::RootCntW-1:0]   cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic [RemW-1:0]                 rem_n, trial;

  assign rem_n = {rem_q[RemW-3:0], x_q[cbfc_pkg::RadW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    x_d = x_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      x_d = {x_q[cbfc_pkg::RadW-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d = rem_n - trial;
        root_d = {root_q[cbfc_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d = rem_n;
        root_d = {root_q[cbfc_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cbfc_pkg::RootCntW'(cbfc_pkg::RootW - 1)) begin
        busy_d = 1'b0;
      end
    end else if (start_i) begin
      x_d = rad_i;
      rem_d = '0;
      root_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/concrete_biaxial_failure_check.sv =====
// A new input word is taken only after the previous point has left the datapath.
// Each point uses six passes of the bit-serial multiplier and one bit-serial square root.
// A new word is taken while a finished result still waits in the output register;
// a stalled result holds the following point in its last step.
// Reset: ft = 0, fc = 1.0, element flag cleared, no result pending.
module concrete_biaxial_failure_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbfc_cfg_if.sink    cfg_i,
  cbfc_in_if.sink     in_i,
  cbfc_out_if.source  out_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StWaitD = 4'd2;
  localparam logic [3:0] StShift = 4'd3;
  localparam logic [3:0] StWaitT = 4'd4;
  localparam logic [3:0] StWaitR = 4'd5;
  localparam logic [3:0] StCond  = 4'd6;
  localparam logic [3:0] StWaitC1 = 4'd7;
  localparam logic [3:0] StWaitC2 = 4'd8;
  localparam logic [3:0] StWaitT1 = 4'd9;
  localparam logic [3:0] StWaitT2 = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  localparam int unsigned OpW = cbfc_pkg::OpW;
  localparam int unsigned WideW = OpW + 1;

  logic [3:0] state_q, state_d;

  logic [cbfc_pkg::StrengthW-1:0] ft_q, fc_q;
  logic signed [cbfc_pkg::StressW-1:0] sx_q, sy_q, t_q;
  logic last_q;
  logic signed [cbfc_pkg::SumW-1:0] m_q;
  logic signed [cbfc_pkg::PrinW-1:0] p1_q, p2_q;
  logic cc_q, cc_ok_q, tc_ok_q;
  logic fso_q;
  logic out_valid_q, pf_q, ef_q, ed_q;

  cbfc_pkg::mul_cmd_t mul_cmd;
  logic mul_busy;
  logic signed [cbfc_pkg::AccW-1:0] acc;
  logic sqrt_start, sqrt_busy;
  logic [cbfc_pkg::RootW-1:0] root;

  logic signed [cbfc_pkg::SumW-1:0] diff, m_c;
  logic [cbfc_pkg::SumW-1:0] d_mag;
  logic [cbfc_pkg::StressW-1:0] t_mag;
  logic signed [cbfc_pkg::PrinW-1:0] r2;
  logic signed [WideW-1:0] p1_w, p2_w, fc_w, ft_w, m_w;
  logic signed [WideW-1:0] lhs25, rhs48, x_w, m10, v_w;
  logic [WideW-1:0] x_mag, m10_mag, m_mag, p1_mag, v_mag;
  logic fail;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= '0;
      fc_q <= cbfc_pkg::CompressiveReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cbfc_pkg::RegTensile: ft_q <= cfg_i.data[cbfc_pkg::StrengthW-1:0];
        cbfc_pkg::RegCompressive: fc_q <= cfg_i.data[cbfc_pkg::StrengthW-1:0];
        default: ;
      endcase
    end
  end

  assign m_c = cbfc_pkg::SumW'(sx_q) + cbfc_pkg::SumW'(sy_q);
  assign diff = cbfc_pkg::SumW'(sx_q) - cbfc_pkg::SumW'(sy_q);
  assign d_mag = diff[cbfc_pkg::SumW-1] ? cbfc_pkg::SumW'(-diff) : cbfc_pkg::SumW'(diff);
  assign t_mag = t_q[cbfc_pkg::StressW-1] ? cbfc_pkg::StressW'(-t_q) : cbfc_pkg::StressW'(t_q);
  assign r2 = $signed({2'b00, root, 1'b0});

  assign p1_w = WideW'(p1_q);
  assign p2_w = WideW'(p2_q);
  assign m_w = WideW'(m_q);
  assign fc_w = $signed({{(WideW - cbfc_pkg::StrengthW){1'b0}}, fc_q});
  assign ft_w = $signed({{(WideW - cbfc_pkg::StrengthW){1'b0}}, ft_q});
  assign lhs25 = (p2_w <<< 4) + (p2_w <<< 3) + p2_w;
  assign rhs48 = -((fc_w <<< 5) + (fc_w <<< 4));
  assign x_w = (p2_w <<< 2) + p2_w + (p1_w <<< 4) + (p1_w <<< 1) + p1_w;
  assign m10 = (m_w <<< 3) + (m_w <<< 1);
  assign v_w = (fc_w <<< 3) + (fc_w <<< 1) + (p2_w <<< 2);
  assign x_mag = x_w[WideW-1] ? WideW'(-x_w) : WideW'(x_w);
  assign m10_mag = m10[WideW-1] ? WideW'(-m10) : WideW'(m10);
  assign m_mag = m_w[WideW-1] ? WideW'(-m_w) : WideW'(m_w);
  assign p1_mag = p1_w[WideW-1] ? WideW'(-p1_w) : WideW'(p1_w);
  assign v_mag = v_w[WideW-1] ? WideW'(-v_w) : WideW'(v_w);

  always_comb begin
    state_d = state_q;
    mul_cmd = '0;
    sqrt_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_i.valid) state_d = StPrep;
      end
      StPrep: begin
        mul_cmd.start = 1'b1;
        mul_cmd.clear = 1'b1;
        mul_cmd.a = OpW'(d_mag);
        mul_cmd.b = OpW'(d_mag);
        state_d = StWaitD;
      end
      StWaitD: begin
        if (!mul_busy) begin
          mul_cmd.shr2 = 1'b1;
          state_d = StShift;
        end
      end
      StShift: begin
        mul_cmd.start = 1'b1;
        mul_cmd.a = OpW'(t_mag);
        mul_cmd.b = OpW'(t_mag);
        state_d = StWaitT;
      end
      StWaitT: begin
        if (!mul_busy) begin
          sqrt_start = 1'b1;
          state_d = StWaitR;
        end
      end
      StWaitR: begin
        if (!sqrt_busy) state_d = StCond;
      end
      StCond: begin
        mul_cmd.start = 1'b1;
        mul_cmd.clear = 1'b1;
        mul_cmd.a = m10_mag[OpW-1:0];
        mul_cmd.b = m_mag[OpW-1:0];
        state_d = StWaitC1;
      end
      StWaitC1: begin
        if (!mul_busy) begin
          mul_cmd.start = 1'b1;
          mul_cmd.neg = x_w[WideW-1];
          mul_cmd.a = x_mag[OpW-1:0];
          mul_cmd.b = fc_w[OpW-1:0];
          state_d = StWaitC2;
        end
      end
      StWaitC2: begin
        if (!mul_busy) begin
          mul_cmd.start = 1'b1;
          mul_cmd.clear = 1'b1;
          mul_cmd.neg = p1_w[WideW-1];
          mul_cmd.a = OpW'((fc_w <<< 2) + fc_w);
          mul_cmd.b = p1_mag[OpW-1:0];
          state_d = StWaitT1;
        end
      end
      StWaitT1: begin
        if (!mul_busy) begin
          mul_cmd.start = 1'b1;
          mul_cmd.neg = !v_w[WideW-1];
          mul_cmd.a = v_mag[OpW-1:0];
          mul_cmd.b = ft_w[OpW-1:0];
          state_d = StWaitT2;
        end
      end
      StWaitT2: begin
        if (!mul_busy) state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign fail = (cc_q && ((m_q == '0) || cc_ok_q)) ||
                (p2_q[cbfc_pkg::PrinW-1] ? ((fc_q == '0) || tc_ok_q)
                                         : (p1_w >= (ft_w <<< 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fso_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
        fso_q <= last_q ? 1'b0 : (fso_q | fail);
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_i.valid) begin
      sx_q <= in_i.stress_x;
      sy_q <= in_i.stress_y;
      t_q <= in_i.shear_xy;
      last_q <= in_i.last_point;
    end
    if (state_q == StPrep) m_q <= m_c;
    if (state_q == StWaitR) begin
      p1_q <= cbfc_pkg::PrinW'(m_q) + r2;
      p2_q <= cbfc_pkg::PrinW'(m_q) - r2;
    end
    if (state_q == StCond) cc_q <= (lhs25 < rhs48);
    if (state_q == StWaitC2 && !mul_busy) cc_ok_q <= !acc[cbfc_pkg::AccW-1];
    if (state_q == StWaitT2 && !mul_busy) tc_ok_q <= !acc[cbfc_pkg::AccW-1];
    if (state_q == StDone && (!out_valid_q || out_o.ready)) begin
      pf_q <= fail;
      ef_q <= fso_q | fail;
      ed_q <= last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.point_failed = pf_q;
  assign out_o.element_failed = ef_q;
  assign out_o.element_done = ed_q;

  cbfc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .busy_o (mul_busy),
    .acc_o  (acc)
  );

  cbfc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc[cbfc_pkg::RadW-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

endmodule
